/* sv/gflm_pkg.sv */
// ----------------------------------------------------------------------------
// gflm_pkg: shared types and constants for the group-filtered L1 medoid block
// Field widths, register indexes, the load queue entry and the search states.
// ----------------------------------------------------------------------------
package gflm_pkg;

  localparam int COORD_W    = 32;
  localparam int SIDX_W     = 6;
  localparam int DIDX_W     = 12;
  localparam int GROUP_W    = 8;
  localparam int SUM_W      = 56;
  localparam int CNT_W      = 7;
  localparam int DIMS_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_DIM_COUNT    = 2'd1,
    CFG_TARGET_GROUP = 2'd2,
    CFG_USE_ALL      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]   sample_count;
    logic [DIMS_W-1:0]  dim_count;
    logic [GROUP_W-1:0] target_group;
    logic               use_all;
  } cfg_t;

  // One load request after classification
  typedef struct packed {
    logic [COORD_W-1:0] coord_value;
    logic [SIDX_W-1:0]  sample_index;
    logic [DIDX_W-1:0]  dim_index;
    logic [GROUP_W-1:0] group_id;
    logic               last;
    logic               coord_ok;
    logic               group_ok;
  } entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_DONE
  } back_state_t;

endpackage

/* sv/gflm_front.sv */
// ----------------------------------------------------------------------------
// gflm_front: input stage of the medoid block
// Registers each load request and flags whether its store addresses are valid.
// ----------------------------------------------------------------------------
module gflm_front #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_DIMS    = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gflm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  output logic                             push_valid,
  input  logic                             push_ready,
  output gflm_pkg::entry_t                 push_data
);

  logic             vld_r, vld_nxt;
  gflm_pkg::entry_t ent_r, ent_nxt;
  logic             take;

  assign in_tready  = !vld_r || push_ready;
  assign take       = in_tvalid && in_tready;
  assign push_valid = vld_r;
  assign push_data  = ent_r;

  always_comb begin
    ent_nxt              = ent_r;
    ent_nxt.coord_value  = in_tdata[31:0];
    ent_nxt.sample_index = in_tdata[37:32];
    ent_nxt.dim_index    = in_tdata[49:38];
    ent_nxt.group_id     = in_tdata[57:50];
    ent_nxt.last         = in_tlast;
    ent_nxt.group_ok     = int'(in_tdata[37:32]) < MAX_SAMPLES;
    ent_nxt.coord_ok     = (int'(in_tdata[37:32]) < MAX_SAMPLES) &&
                           (int'(in_tdata[49:38]) < MAX_DIMS);
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

/* sv/gflm_fifo.sv */
// ----------------------------------------------------------------------------
// gflm_fifo: short load queue
// Decouples request intake from the store and search engine.
// ----------------------------------------------------------------------------
module gflm_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  gflm_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output gflm_pkg::entry_t pop_data
);

  gflm_pkg::entry_t                  slot_r [gflm_pkg::QDEPTH];
  logic [gflm_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [gflm_pkg::QPTR_W:0]         count_r, count_nxt;
  logic                              do_push, do_pop;

  assign push_ready = count_r != (gflm_pkg::QPTR_W + 1)'(gflm_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/gflm_back.sv */
// ----------------------------------------------------------------------------
// gflm_back: store and search engine
// Writes loads into the stores; on the last load walks every (i, j, k) triple
// through a four-stage pipeline and keeps the sample with the least sum.
// ----------------------------------------------------------------------------
module gflm_back #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_DIMS    = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gflm_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  gflm_pkg::entry_t                  q_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gflm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser
);

  localparam int SW    = $clog2(MAX_SAMPLES);
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DEPTH = MAX_SAMPLES * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUMW  = gflm_pkg::SUM_W;

  gflm_pkg::back_state_t state_r, state_nxt;

  // stores
  logic [gflm_pkg::COORD_W-1:0] coord_mem [DEPTH];
  logic [gflm_pkg::GROUP_W-1:0] group_mem [MAX_SAMPLES];

  // search bounds
  logic [SW:0]   n_c;
  logic [DW:0]   dims_c;
  logic [SW-1:0] nlast_r;
  logic [DW-1:0] klast_r;
  logic          zd_r;

  // sequencer
  logic [SW-1:0] i_r, j_r;
  logic [DW-1:0] k_r;
  logic [AW-1:0] base_i_r, base_j_r;
  logic [AW-1:0] ra, rb, wa;
  logic          first0, klast0, jlast0, last0, fin0, start, run;

  // stage 1: store data
  logic                         v1_r, first1_r, last1_r, self1_r, fin1_r;
  logic [SW-1:0]                idx1_r;
  logic [gflm_pkg::COORD_W-1:0] a_q, b_q;
  logic [gflm_pkg::GROUP_W-1:0] gi_q, gj_q;

  // stage 2: absolute difference
  logic                         kept_i, kept_j;
  logic [32:0]                  diff, ndiff;
  logic                         v2_r, first2_r, last2_r, fin2_r, keep2_r, en2_r;
  logic [SW-1:0]                idx2_r;
  logic [31:0]                  absd2_r;

  // stage 3: running sum
  logic [SUMW-1:0]              base_sum, sum_nxt;
  logic [SUMW:0]                sum_wide;
  logic                         v3_r, last3_r, fin3_r, keep3_r;
  logic [SW-1:0]                idx3_r;
  logic [SUMW-1:0]              sum_r;

  // stage 4: best so far
  logic                         found_r;
  logic [SUMW-1:0]              best_sum_r;
  logic [SW-1:0]                best_idx_r;

  logic                         out_vld_r, load_out;
  logic [gflm_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                         out_found_r;

  // clamp the counts
  always_comb begin
    if (int'(cfg.sample_count) < MAX_SAMPLES) begin
      n_c = (SW + 1)'(cfg.sample_count);
    end else begin
      n_c = (SW + 1)'(MAX_SAMPLES);
    end
    if (int'(cfg.dim_count) < MAX_DIMS) begin
      dims_c = (DW + 1)'(cfg.dim_count);
    end else begin
      dims_c = (DW + 1)'(MAX_DIMS);
    end
  end

  assign run    = state_r == gflm_pkg::B_RUN;
  assign first0 = (j_r == '0) && (k_r == '0);
  assign klast0 = k_r == klast_r;
  assign jlast0 = j_r == nlast_r;
  assign last0  = klast0 && jlast0;
  assign fin0   = run && last0 && (i_r == nlast_r);
  assign ra     = base_i_r + AW'(k_r);
  assign rb     = base_j_r + AW'(k_r);
  assign wa     = AW'(q_data.sample_index) * AW'(MAX_DIMS) + AW'(q_data.dim_index);
  assign load_out = (state_r == gflm_pkg::B_DONE) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    start     = 1'b0;
    case (state_r)
      gflm_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_data.last) begin
          start = 1'b1;
          if (n_c == '0) begin
            state_nxt = gflm_pkg::B_DONE;
          end else begin
            state_nxt = gflm_pkg::B_RUN;
          end
        end
      end
      gflm_pkg::B_RUN: begin
        if (fin0) begin
          state_nxt = gflm_pkg::B_DRAIN;
        end
      end
      gflm_pkg::B_DRAIN: begin
        if (v3_r && fin3_r) begin
          state_nxt = gflm_pkg::B_DONE;
        end
      end
      gflm_pkg::B_DONE: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = gflm_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = gflm_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gflm_pkg::B_IDLE;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= run;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // stores: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (q_ready && q_valid && q_data.coord_ok) begin
      coord_mem[wa] <= q_data.coord_value;
    end
    a_q <= coord_mem[ra];
    b_q <= coord_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid && q_data.group_ok) begin
      group_mem[SW'(q_data.sample_index)] <= q_data.group_id;
    end
    gi_q <= group_mem[i_r];
    gj_q <= group_mem[j_r];
  end

  // sequencer: k innermost, then j, then i
  always_ff @(posedge clk) begin
    if (start) begin
      nlast_r  <= SW'(n_c - 1'b1);
      klast_r  <= (dims_c == '0) ? '0 : DW'(dims_c - 1'b1);
      zd_r     <= dims_c == '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      base_i_r <= '0;
      base_j_r <= '0;
    end else if (run) begin
      if (!klast0) begin
        k_r <= k_r + 1'b1;
      end else begin
        k_r <= '0;
        if (!jlast0) begin
          j_r      <= j_r + 1'b1;
          base_j_r <= base_j_r + AW'(MAX_DIMS);
        end else begin
          j_r      <= '0;
          base_j_r <= '0;
          i_r      <= i_r + 1'b1;
          base_i_r <= base_i_r + AW'(MAX_DIMS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= first0;
    last1_r  <= last0;
    self1_r  <= i_r == j_r;
    fin1_r   <= fin0;
    idx1_r   <= i_r;
  end

  assign kept_i = cfg.use_all || (gi_q == cfg.target_group);
  assign kept_j = cfg.use_all || (gj_q == cfg.target_group);
  assign diff   = {a_q[31], a_q} - {b_q[31], b_q};
  assign ndiff  = -diff;

  always_ff @(posedge clk) begin
    first2_r <= first1_r;
    last2_r  <= last1_r;
    fin2_r   <= fin1_r;
    idx2_r   <= idx1_r;
    keep2_r  <= kept_i;
    en2_r    <= kept_i && kept_j && !self1_r && !zd_r;
    absd2_r  <= diff[32] ? ndiff[31:0] : diff[31:0];
  end

  // accumulate with saturation; clamping each step equals clamping per pair
  always_comb begin
    base_sum = first2_r ? '0 : sum_r;
    sum_wide = {1'b0, base_sum} + (SUMW + 1)'(absd2_r);
    if (!en2_r) begin
      sum_nxt = base_sum;
    end else if (sum_wide[SUMW]) begin
      sum_nxt = gflm_pkg::SUM_MAX;
    end else begin
      sum_nxt = sum_wide[SUMW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      sum_r <= sum_nxt;
    end
    last3_r <= last2_r;
    fin3_r  <= fin2_r;
    keep3_r <= keep2_r;
    idx3_r  <= idx2_r;
  end

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (start) begin
      found_r    <= 1'b0;
      best_sum_r <= '0;
      best_idx_r <= '0;
    end else if (v3_r && last3_r && keep3_r && (!found_r || (sum_r < best_sum_r))) begin
      found_r    <= 1'b1;
      best_sum_r <= sum_r;
      best_idx_r <= idx3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r  <= {2'b00, best_sum_r, gflm_pkg::SIDX_W'(best_idx_r)};
      out_found_r <= found_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

/* sv/group_filtered_l1_medoid.sv */
// ----------------------------------------------------------------------------
// group_filtered_l1_medoid: group-filtered L1 medoid search
// Loads Q16.16 sample coordinates and reports the sample with the least
// summed L1 distance to the other samples of the chosen group (or of all samples when use_all is set).
// ----------------------------------------------------------------------------
// Usage:
//  - in_* stream: one request per coordinate. in_tdata carries coord_value,
//    sample_index, dim_index and group_id; in_tlast ends the load and starts
//    the search. Loads are taken one per cycle while the engine is free.
//  - out_* stream: one result per request with in_tlast set. out_tdata
//    carries medoid_index and min_sum; out_tuser is the found flag, clear
//    when no sample passes the group filter (index and sum then read 0).
//  - cfg_* port: write sample_count, dim_count, target_group and use_all
//    only while the block is idle.
//  - Search: the engine walks n * n * max(dims, 1) store reads, one per
//    cycle through a dual-read coordinate store, with n and dims the
//    clamped counts, then drains the pipeline before the result is presented.
//  - A short queue in front of the engine holds loads during a search.
//  - Reset clears the control state and loads the register reset values;
//    the stores are not cleared and must be written before they are read.
//  - When out_tready is low the result is held; the engine goes on taking
//    loads, but the next result waits and the queue fills until in_tready drops.
// ----------------------------------------------------------------------------
module group_filtered_l1_medoid #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_DIMS    = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // cfg
  input  logic                               cfg_we,
  input  logic [gflm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gflm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // load stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // coord_value[31:0], sample_index[37:32], dim_index[49:38], group_id[57:50]
  input  logic [gflm_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // medoid_index[5:0], min_sum[61:6]
  output logic [gflm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // found[0]
  output logic                               out_tuser
);

  gflm_pkg::cfg_t   cfg_r;
  gflm_pkg::entry_t push_data, pop_data;
  logic             push_valid, push_ready, pop_valid, pop_ready;

  // Configuration registers; write only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= '0;
      cfg_r.dim_count    <= gflm_pkg::DIMS_W'(1);
      cfg_r.target_group <= gflm_pkg::GROUP_W'(1);
      cfg_r.use_all      <= 1'b0;
    end else if (cfg_we) begin
      case (gflm_pkg::cfg_idx_t'(cfg_index))
        gflm_pkg::CFG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_wdata[6:0];
        gflm_pkg::CFG_DIM_COUNT:    cfg_r.dim_count    <= cfg_wdata[12:0];
        gflm_pkg::CFG_TARGET_GROUP: cfg_r.target_group <= cfg_wdata[7:0];
        gflm_pkg::CFG_USE_ALL:      cfg_r.use_all      <= cfg_wdata[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Front: register and classify each load request
  gflm_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_DIMS    (MAX_DIMS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue: hold loads while a search runs
  gflm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: write the stores, run the search, present the result
  gflm_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_DIMS    (MAX_DIMS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_data     (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
